// ===== hdl/trfsf_pkg.sv =====
// Shared constants and types for the two-rule fuzzy state-feedback core.
// No dependencies; used by trfsf_div25 and two_rule_fuzzy_state_feedback_core.
package trfsf_pkg;

   localparam int GAIN_W     = 24;
   localparam int HOLD_W     = 16;
   localparam int DRV_W      = 40;
   localparam int WB_W       = 18;
   localparam int LAW_SHIFT  = 12;
   localparam int LAW_HALF   = 2048;
   localparam int SPAN       = 204800;
   localparam int SPAN_HALF  = 102400;
   localparam int SPAN_SHIFT = 13;
   localparam int DIV_TAIL   = 25;
   localparam int BP_M30     = -122880;
   localparam int BP_M20     = -81920;
   localparam int BP_P30     = 122880;
   localparam int BP_P40     = 163840;

   localparam logic signed [GAIN_W-1:0] RST_GAIN_A0 = 24'sd75699;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_A1 = 24'sd35123;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_A2 = 24'sd2074;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_B0 = 24'sd113690;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_B1 = 24'sd52429;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_B2 = -24'sd3251;
   localparam logic [HOLD_W-1:0]        RST_HOLD    = 16'd1000;

   localparam logic signed [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
   localparam logic signed [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_GAIN_A0  = 3'd0,
      REG_GAIN_A1  = 3'd1,
      REG_GAIN_A2  = 3'd2,
      REG_GAIN_B0  = 3'd3,
      REG_GAIN_B1  = 3'd4,
      REG_GAIN_B2  = 3'd5,
      REG_HOLD_OFF = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic saturated;
      logic no_membership;
      logic holding;
   } flags_type;

endpackage

// ===== hdl/trfsf_div25.sv =====
// Bit-serial restoring divider: floor division of a signed value by DIV_TAIL.
// Depends on trfsf_pkg.
module trfsf_div25 #(
   parameter int WIDTH = 46
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [WIDTH-1:0] numer,
   output logic                    done,
   output logic signed [WIDTH:0]   quot
);
   import trfsf_pkg::*;

   localparam int QW  = WIDTH + 1;
   localparam int CNW = $clog2(QW + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [QW-1:0]        q_ff, q_in;
   logic [4:0]           rem_ff, rem_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic signed [QW-1:0] numer_x;
   logic [5:0]           trial;
   logic                 fits;

   assign numer_x = QW'(numer);
   assign trial   = {rem_ff, q_ff[QW-1]};
   assign fits    = trial >= 6'(DIV_TAIL);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = numer[WIDTH-1];
         q_in    = numer[WIDTH-1] ? QW'(-numer_x + QW'(DIV_TAIL - 1)) : QW'(numer_x);
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? 5'(trial - 6'(DIV_TAIL)) : trial[4:0];
         q_in   = {q_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

// ===== hdl/two_rule_fuzzy_state_feedback_core.sv =====
// Top level of the two-rule fuzzy state-feedback core: bit-serial dot products,
// serial blend multiply and divide, hold-off counter. Uses trfsf_pkg, trfsf_div25.
//
//   channel  dir  handshake               payload
//   req_     in   req_tvalid/req_tready   tdata: state_x, state_y, state_z
//   rsp_     out  rsp_tvalid/rsp_tready   tdata: drive; tuser: flags
//   csr_     in   csr_valid/csr_ready     csr_index, csr_wdata
//
// One item at a time. A computed sample passes through the MSB-first
// multiply-accumulate over the state bits, the 18-step weight multiply and the
// restoring divide. Hold-off and empty-membership samples go straight to the result stage.
// Reset is synchronous; it loads the register defaults and clears the sample count.
// A waiting result does not stop the next transfer in; the core stalls only at the
// end of a sample while the previous result is still untaken.
module two_rule_fuzzy_state_feedback_core #(
   parameter int STATE_WIDTH = 24,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // state_x, state_y, state_z from bit 0 up, zero padded to bytes
   input  logic [((3*STATE_WIDTH+7)/8)*8-1:0]             req_tdata,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // drive
   output logic [trfsf_pkg::DRV_W-1:0]                    rsp_tdata,
   // holding, no_membership, saturated from bit 0 up
   output trfsf_pkg::flags_type                           rsp_tuser,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [2:0]                                     csr_index,
   input  logic [trfsf_pkg::GAIN_W-1:0]                   csr_wdata
);
   import trfsf_pkg::*;

   localparam int SW  = STATE_WIDTH;
   localparam int CW  = COUNT_WIDTH;
   localparam int AW  = GAIN_W + SW + 2;
   localparam int LW  = AW + 1 - LAW_SHIFT;
   localparam int DW  = LW + 1;
   localparam int NW  = DW + WB_W + 1;
   localparam int MW  = NW - SPAN_SHIFT;
   localparam int FW  = MW + 2;
   localparam int XW  = (FW > DRV_W) ? FW : DRV_W;
   localparam int BW  = ((SW > 18) ? SW : 18) + 2;
   localparam int HW  = (CW > HOLD_W) ? CW : HOLD_W;
   localparam int KW  = $clog2((SW > WB_W) ? SW : WB_W);

   typedef enum logic [2:0] {
      S_IDLE, S_DOT, S_LAW, S_MUL, S_DIVGO, S_DIV, S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [GAIN_W-1:0]  gain_ff [6];
   logic [HOLD_W-1:0]         hold_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic [KW-1:0]             cnt_ff, cnt_in;
   logic [SW-1:0]             sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [WB_W-1:0]           wb_ff, wb_in;
   logic signed [AW-1:0]      acca_ff, acca_in, accb_ff, accb_in;
   logic signed [LW-1:0]      ua_ff, ua_in;
   logic signed [DW-1:0]      d_ff, d_in;
   logic signed [NW-1:0]      p_ff, p_in;
   logic [DRV_W-1:0]          st_drive_ff, st_drive_in;
   flags_type                 st_flags_ff, st_flags_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DRV_W-1:0]          rsp_drive_ff, rsp_drive_in;
   flags_type                 rsp_flags_ff, rsp_flags_in;

   logic signed [SW-1:0]      in_x;
   logic signed [BW-1:0]      x_ext;
   logic                      in_hold, in_empty;
   logic [WB_W-1:0]           in_wb;
   logic signed [AW-1:0]      ta, tb;
   logic signed [AW:0]        na, nb;
   logic signed [LW-1:0]      ua, ub;
   logic signed [NW-1:0]      n_round;
   logic signed [MW-1:0]      div_numer;
   logic                      div_start, div_done;
   logic signed [MW:0]        div_quot;
   logic signed [XW-1:0]      sum_x;
   logic                      over_hi, over_lo;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // membership decode at the input transfer
   assign in_x     = $signed(req_tdata[SW-1:0]);
   assign x_ext    = BW'(in_x);
   assign in_hold  = HW'(count_ff) < HW'(hold_ff);
   assign in_empty = (x_ext < BW'(BP_M30)) || (x_ext > BW'(BP_P40));
   always_comb begin
      if (x_ext >= BW'(BP_M20) && x_ext < BW'(BP_P30)) begin
         in_wb = WB_W'(x_ext - BW'(BP_M20));
      end else if (x_ext >= BW'(BP_P30)) begin
         in_wb = WB_W'(SPAN);
      end else begin
         in_wb = '0;
      end
   end

   // MSB-first multiply-accumulate terms
   assign ta = (sx_ff[SW-1] ? AW'(gain_ff[0]) : '0) + (sy_ff[SW-1] ? AW'(gain_ff[1]) : '0)
             + (sz_ff[SW-1] ? AW'(gain_ff[2]) : '0);
   assign tb = (sx_ff[SW-1] ? AW'(gain_ff[3]) : '0) + (sy_ff[SW-1] ? AW'(gain_ff[4]) : '0)
             + (sz_ff[SW-1] ? AW'(gain_ff[5]) : '0);

   assign na = -(AW+1)'(acca_ff) + (AW+1)'(LAW_HALF);
   assign nb = -(AW+1)'(accb_ff) + (AW+1)'(LAW_HALF);
   assign ua = na[AW:LAW_SHIFT];
   assign ub = nb[AW:LAW_SHIFT];

   assign n_round   = p_ff + NW'(SPAN_HALF);
   assign div_numer = n_round[NW-1:SPAN_SHIFT];
   assign div_start = (state_ff == S_DIVGO);

   assign sum_x   = XW'(FW'(ua_ff) + FW'(div_quot));
   assign over_hi = sum_x > XW'(DRV_MAX);
   assign over_lo = sum_x < XW'(DRV_MIN);

   trfsf_div25 #(.WIDTH(MW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cnt_in       = cnt_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      wb_in        = wb_ff;
      acca_in      = acca_ff;
      accb_in      = accb_ff;
      ua_in        = ua_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      st_drive_in  = st_drive_ff;
      st_flags_in  = st_flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_drive_in = rsp_drive_ff;
      rsp_flags_in = rsp_flags_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (count_ff != {CW{1'b1}}) begin
                  count_in = count_ff + 1'b1;
               end
               sx_in       = req_tdata[SW-1:0];
               sy_in       = req_tdata[2*SW-1:SW];
               sz_in       = req_tdata[3*SW-1:2*SW];
               wb_in       = in_wb;
               cnt_in      = '0;
               st_drive_in = '0;
               st_flags_in = '{saturated: 1'b0, no_membership: !in_hold && in_empty,
                               holding: in_hold};
               state_in    = (in_hold || in_empty) ? S_FIN : S_DOT;
            end
         end
         S_DOT: begin
            acca_in = (cnt_ff == '0) ? -ta : (acca_ff <<< 1) + ta;
            accb_in = (cnt_ff == '0) ? -tb : (accb_ff <<< 1) + tb;
            sx_in   = sx_ff << 1;
            sy_in   = sy_ff << 1;
            sz_in   = sz_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == KW'(SW - 1)) begin
               state_in = S_LAW;
            end
         end
         S_LAW: begin
            ua_in    = ua;
            d_in     = DW'(ub) - DW'(ua);
            p_in     = '0;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            p_in   = (p_ff <<< 1) + (wb_ff[WB_W-1] ? NW'(d_ff) : '0);
            wb_in  = wb_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == KW'(WB_W - 1)) begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               st_drive_in = over_hi ? DRV_MAX : (over_lo ? DRV_MIN : sum_x[DRV_W-1:0]);
               st_flags_in = '{saturated: over_hi || over_lo, no_membership: 1'b0,
                               holding: 1'b0};
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = st_drive_ff;
               rsp_flags_in = st_flags_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff[0]   <= RST_GAIN_A0;
         gain_ff[1]   <= RST_GAIN_A1;
         gain_ff[2]   <= RST_GAIN_A2;
         gain_ff[3]   <= RST_GAIN_B0;
         gain_ff[4]   <= RST_GAIN_B1;
         gain_ff[5]   <= RST_GAIN_B2;
         hold_ff      <= RST_HOLD;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (reg_index_type'(csr_index))
               REG_GAIN_A0:  gain_ff[0] <= csr_wdata;
               REG_GAIN_A1:  gain_ff[1] <= csr_wdata;
               REG_GAIN_A2:  gain_ff[2] <= csr_wdata;
               REG_GAIN_B0:  gain_ff[3] <= csr_wdata;
               REG_GAIN_B1:  gain_ff[4] <= csr_wdata;
               REG_GAIN_B2:  gain_ff[5] <= csr_wdata;
               REG_HOLD_OFF: hold_ff    <= csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
      end
      cnt_ff       <= cnt_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      sz_ff        <= sz_in;
      wb_ff        <= wb_in;
      acca_ff      <= acca_in;
      accb_ff      <= accb_in;
      ua_ff        <= ua_in;
      d_ff         <= d_in;
      p_ff         <= p_in;
      st_drive_ff  <= st_drive_in;
      st_flags_ff  <= st_flags_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_flags_ff <= rsp_flags_in;
   end

endmodule

// ===== dv/tb_two_rule_fuzzy_state_feedback_core.sv =====
// Testbench for two_rule_fuzzy_state_feedback_core: streams plant states in and
// checks every drive word and flag against an in-bench fixed-point predictor.
// Depends on hdl/trfsf_pkg.sv and hdl/two_rule_fuzzy_state_feedback_core.sv.
module tb_two_rule_fuzzy_state_feedback_core;
   timeunit 1ns;
   timeprecision 1ps;
   import trfsf_pkg::*;

   localparam int SW = 24;
   localparam int CW = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [DRV_W-1:0] drive;
      flags_type        flags;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [3*SW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DRV_W-1:0] rsp_tdata;
   flags_type rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   logic signed [GAIN_W-1:0] gain_sh [6];
   logic [HOLD_W-1:0] hold_sh;
   logic [CW-1:0] sample_cnt;
   drive_result_type drive_q [$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   two_rule_fuzzy_state_feedback_core #(.STATE_WIDTH(SW), .COUNT_WIDTH(CW)) u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready = quiet ? 1'b1 : ($urandom_range(99) >= 30);
   end

   task automatic report(string what, logic [DRV_W-1:0] got, logic [DRV_W-1:0] exp);
      errors++;
      $display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, exp);
   endtask

   always @(posedge clock) begin
      drive_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            report("unexpected transfer", rsp_tdata, '0);
         end else begin
            e = drive_q.pop_front();
            if (rsp_tdata !== e.drive) report("drive", rsp_tdata, e.drive);
            if (rsp_tuser.holding !== e.flags.holding)
               report("holding", DRV_W'(rsp_tuser.holding), DRV_W'(e.flags.holding));
            if (rsp_tuser.no_membership !== e.flags.no_membership)
               report("no_membership", DRV_W'(rsp_tuser.no_membership),
                      DRV_W'(e.flags.no_membership));
            if (rsp_tuser.saturated !== e.flags.saturated)
               report("saturated", DRV_W'(rsp_tuser.saturated), DRV_W'(e.flags.saturated));
         end
      end
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint feedback_law(longint s [3], int first);
      longint acc;
      acc = 0;
      for (int k = 0; k < 3; k++) acc += longint'(gain_sh[first + k]) * s[k];
      return floor_div(-acc + LAW_HALF, 1 << LAW_SHIFT);
   endfunction

   // advances the sample count as the core does
   function automatic drive_result_type predict_drive(logic signed [SW-1:0] sx,
                                                      logic signed [SW-1:0] sy,
                                                      logic signed [SW-1:0] sz);
      drive_result_type r;
      longint s [3];
      longint x, wa, wb, d;
      s[0] = sx; s[1] = sy; s[2] = sz;
      x = s[0];
      d = 0;
      r.flags = '0;
      if (sample_cnt < hold_sh) begin
         r.flags.holding = 1'b1;
      end else begin
         if (x >= BP_M30 && x <= BP_M20) wa = SPAN;
         else if (x > BP_M20 && x < BP_P30) wa = BP_P30 - x;
         else wa = 0;
         if (x >= BP_M20 && x < BP_P30) wb = x - BP_M20;
         else if (x >= BP_P30 && x <= BP_P40) wb = SPAN;
         else wb = 0;
         if (wa + wb == 0) begin
            r.flags.no_membership = 1'b1;
         end else begin
            d = floor_div(feedback_law(s, 0) * wa + feedback_law(s, 3) * wb + SPAN_HALF,
                          SPAN);
            if (d > longint'(DRV_MAX)) begin
               d = DRV_MAX;
               r.flags.saturated = 1'b1;
            end else if (d < longint'(DRV_MIN)) begin
               d = DRV_MIN;
               r.flags.saturated = 1'b1;
            end
         end
      end
      if (sample_cnt != {CW{1'b1}}) sample_cnt++;
      r.drive = d[DRV_W-1:0];
      return r;
   endfunction

   task automatic idle_gap();
      if (!quiet && $urandom_range(99) < 30) repeat ($urandom_range(1, 4)) @(negedge clock);
   endtask

   task automatic send_sample(logic [SW-1:0] sx, logic [SW-1:0] sy, logic [SW-1:0] sz);
      logic taken;
      idle_gap();
      req_tvalid = 1'b1;
      req_tdata = {sz, sy, sx};
      do begin
         @(posedge clock);
         taken = req_tready;
      end while (!taken);
      drive_q.push_back(predict_drive(sx, sy, sz));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_idle();
      while (drive_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [GAIN_W-1:0] value);
      logic taken;
      wait_idle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do begin
         @(posedge clock);
         taken = csr_ready;
      end while (!taken);
      if (idx == REG_HOLD_OFF) hold_sh = value[HOLD_W-1:0];
      else if (idx < REG_HOLD_OFF) gain_sh[idx] = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_gains(logic [GAIN_W-1:0] g [6]);
      for (int i = 0; i < 6; i++) write_reg(reg_index_type'(i), g[i]);
   endtask

   function automatic logic [SW-1:0] rand_state();
      return SW'($urandom());
   endfunction

   function automatic logic [SW-1:0] rand_sched();
      if ($urandom_range(9) == 0) return rand_state();
      return SW'($urandom_range(BP_P40 - BP_M30 + 8192) + BP_M30 - 4096);
   endfunction

   task automatic test_hold_off();
      for (int i = 0; i < 4; i++) send_sample(SW'(BP_M20), rand_state(), rand_state());
      write_reg(REG_HOLD_OFF, GAIN_W'(6));
      for (int i = 0; i < 4; i++) send_sample(SW'(BP_P30), SW'(4096), SW'(-4096));
      write_reg(REG_UNUSED, '1);
      send_sample(SW'(0), SW'(12345), SW'(-777));
   endtask

   task automatic test_breakpoints();
      int xs [] = '{BP_M30 - 1, BP_M30, BP_M30 + 1, BP_M20 - 1, BP_M20, BP_M20 + 1, 0,
                    BP_P30 - 1, BP_P30, BP_P30 + 1, BP_P40 - 1, BP_P40, BP_P40 + 1,
                    -(1 << (SW - 1)), (1 << (SW - 1)) - 1, 1, -1, 2048};
      write_reg(REG_HOLD_OFF, GAIN_W'(0));
      foreach (xs[i]) send_sample(SW'(xs[i]), SW'(40960), SW'(-20480));
   endtask

   task automatic test_gain_extremes();
      logic [GAIN_W-1:0] g [6];
      for (int i = 0; i < 6; i++) g[i] = (i % 2) ? {1'b1, {(GAIN_W-1){1'b0}}}
                                                 : {1'b0, {(GAIN_W-1){1'b1}}};
      write_gains(g);
      send_sample(SW'(BP_P40), {1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}});
      send_sample(SW'(BP_M30), {1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}});
      send_sample(SW'(BP_M20 + 1), {1'b1, {(SW-1){1'b0}}}, {1'b1, {(SW-1){1'b0}}});
      send_sample(SW'(BP_P30 - 1), {1'b0, {(SW-1){1'b1}}}, {1'b0, {(SW-1){1'b1}}});
   endtask

   task automatic test_random();
      logic [GAIN_W-1:0] g [6];
      logic [GAIN_W-1:0] g_rst [6];
      g_rst = '{RST_GAIN_A0, RST_GAIN_A1, RST_GAIN_A2,
                RST_GAIN_B0, RST_GAIN_B1, RST_GAIN_B2};
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 6; i++) begin
            case (ph)
               0: g[i] = g_rst[i];
               1: g[i] = {1'b0, {(GAIN_W-1){1'b1}}};
               2: g[i] = {1'b1, {(GAIN_W-1){1'b0}}};
               default: g[i] = GAIN_W'($urandom());
            endcase
         end
         write_gains(g);
         quiet = (ph == 3);
         for (int n = 0; n < 300; n++) begin
            if ($urandom_range(3) == 0)
               send_sample(rand_sched(), SW'($urandom_range(8191) - 4096),
                           SW'($urandom_range(8191) - 4096));
            else
               send_sample(rand_sched(), rand_state(), rand_state());
         end
         quiet = 1'b0;
      end
   endtask

   // hold-off limit placed just ahead of the running sample count
   task automatic test_hold_edge();
      write_reg(REG_HOLD_OFF, GAIN_W'(sample_cnt) + GAIN_W'(3));
      for (int i = 0; i < 8; i++) send_sample(rand_sched(), rand_state(), rand_state());
   endtask

   initial begin
      gain_sh = '{RST_GAIN_A0, RST_GAIN_A1, RST_GAIN_A2,
                  RST_GAIN_B0, RST_GAIN_B1, RST_GAIN_B2};
      hold_sh = RST_HOLD;
      sample_cnt = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_hold_off();
      test_breakpoints();
      test_gain_extremes();
      test_random();
      test_hold_edge();
      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
